>>> design/dpe_pkg.sv
// Shared types and constants for the DCC packet line encoder.
// Holds the configuration defaults, the job record that the front passes to the back,
// and the sequencer states. It depends on nothing else.
`timescale 1ns / 1ps

package dpe_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned PRE_W     = 5;
  localparam int unsigned DUR_W     = 20;
  localparam int unsigned CNT_W     = 5;

  // Configuration port geometry
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Job queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Preamble limit, minimum duration and reset values of the registers
  localparam logic [PRE_W-1:0] PRE_MAX       = 5'd20;
  localparam logic [PRE_W-1:0] PRE_RST       = 5'd14;
  localparam logic [DUR_W-1:0] ONE_RST       = 20'd11600;
  localparam logic [DUR_W-1:0] ZERO_RST      = 20'd20000;
  localparam logic [DUR_W-1:0] DUR_MIN       = 20'd1;

  // Register indexes (byte address divided by four)
  typedef enum logic [1:0] {
    REG_PREAMBLE = 2'd0,
    REG_ONE_HALF = 2'd1,
    REG_ZERO_HALF = 2'd2
  } reg_idx_t;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [PRE_W-1:0] pre_ones;
    logic [DUR_W-1:0] one_cycles;
    logic [DUR_W-1:0] zero_cycles;
  } cfg_t;

  // One classified byte: preamble bits still to send, the byte and the end flag
  typedef struct packed {
    logic [PRE_W-1:0]  pre_bits;
    logic [BYTE_W-1:0] data;
    logic              last;
  } job_t;

  // Segment of the bit stream the back end is working on
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRE,
    ST_START,
    ST_DATA,
    ST_END
  } seg_t;

  // Status of the back end sequencer
  typedef struct packed {
    logic idle;
    logic half;
  } back_stat_t;

endpackage

>>> design/dcc_packet_line_encoder_top.sv
// DCC packet line encoder: packet bytes in, half-bit line phases out.
// A byte accepted into an idle block passes the job queue and output beat register. One phase
// per cycle while a job is queued and the output drains; each bit is a high then a low phase.
// A byte is a start bit and eight data bits; a packet adds preamble first and an end bit last.
// Reset (synchronous, rst_n low): registers to defaults, queues empty, no packet open.
`timescale 1ns / 1ps

module dcc_packet_line_encoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [dpe_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_last_byte,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_line_level,
  output logic [dpe_pkg::DUR_W-1:0]  out_phase_cycles,
  output logic                       out_run_end,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dpe_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [dpe_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [dpe_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  dpe_pkg::cfg_t       cfg;
  dpe_pkg::job_t       q_wr_job;
  dpe_pkg::job_t       q_rd_job;
  dpe_pkg::back_stat_t back_stat;
  logic                q_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  // Register file
  dpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Byte intake and classification
  dpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_full      (in_full),
    .cfg          (cfg),
    .q_push       (q_push),
    .q_job        (q_wr_job),
    .q_full       (q_full)
  );

  // Job queue
  dpe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_job   (q_wr_job),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_job   (q_rd_job),
    .pop      (q_pop)
  );

  // Bit sequencer and output stage
  dpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .job_valid        (q_valid),
    .job              (q_rd_job),
    .job_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_line_level   (out_line_level),
    .out_phase_cycles (out_phase_cycles),
    .out_run_end      (out_run_end),
    .stat             (back_stat)
  );

  // Releasing a job always leaves its final phase, flagged, in the output stage.
  a_pop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!out_empty && out_run_end))
    else $error("job released without a flagged final phase");

  // Between jobs the sequencer never sits halfway through a bit.
  a_idle_whole_bit: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.idle |-> !back_stat.half)
    else $error("sequencer idle in the middle of a bit");

  // Every phase on the ports has a nonzero duration.
  a_nonzero_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_phase_cycles != '0))
    else $error("phase of zero duration presented");

endmodule

>>> design/dpe_cfg.sv
// Configuration registers of the DCC packet line encoder on an APB-style port.
// Depends on dpe_pkg for register indexes, reset values and the cfg_t record.
`timescale 1ns / 1ps

module dpe_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpe_pkg::ADDR_W-1:0] paddr,
  input  logic [dpe_pkg::DATA_W-1:0] pwdata,
  output logic [dpe_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dpe_pkg::cfg_t              cfg
);

  logic [dpe_pkg::PRE_W-1:0] pre_r, pre_nxt;
  logic [dpe_pkg::DUR_W-1:0] one_r, one_nxt;
  logic [dpe_pkg::DUR_W-1:0] zero_r, zero_nxt;
  logic                      wr_en;
  dpe_pkg::reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = dpe_pkg::reg_idx_t'(paddr[dpe_pkg::ADDR_W-1:2]);

  // Write decode
  always_comb begin
    pre_nxt  = pre_r;
    one_nxt  = one_r;
    zero_nxt = zero_r;
    if (wr_en) begin
      unique case (idx)
        dpe_pkg::REG_PREAMBLE:  pre_nxt  = pwdata[dpe_pkg::PRE_W-1:0];
        dpe_pkg::REG_ONE_HALF:  one_nxt  = pwdata[dpe_pkg::DUR_W-1:0];
        dpe_pkg::REG_ZERO_HALF: zero_nxt = pwdata[dpe_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= dpe_pkg::PRE_RST;
      one_r  <= dpe_pkg::ONE_RST;
      zero_r <= dpe_pkg::ZERO_RST;
    end else begin
      pre_r  <= pre_nxt;
      one_r  <= one_nxt;
      zero_r <= zero_nxt;
    end
  end

  // Read decode returns the raw register contents
  always_comb begin
    unique case (idx)
      dpe_pkg::REG_PREAMBLE:
        prdata = {{(dpe_pkg::DATA_W - dpe_pkg::PRE_W){1'b0}}, pre_r};
      dpe_pkg::REG_ONE_HALF:
        prdata = {{(dpe_pkg::DATA_W - dpe_pkg::DUR_W){1'b0}}, one_r};
      dpe_pkg::REG_ZERO_HALF:
        prdata = {{(dpe_pkg::DATA_W - dpe_pkg::DUR_W){1'b0}}, zero_r};
      default:
        prdata = '0;
    endcase
  end

  // Effective values: the preamble saturates at PRE_MAX and a zero duration is replaced by DUR_MIN.
  assign cfg.pre_ones    = (pre_r > dpe_pkg::PRE_MAX) ? dpe_pkg::PRE_MAX : pre_r;
  assign cfg.one_cycles  = (one_r == '0) ? dpe_pkg::DUR_MIN : one_r;
  assign cfg.zero_cycles = (zero_r == '0) ? dpe_pkg::DUR_MIN : zero_r;

endmodule

>>> design/dpe_front.sv
// Front end of the DCC packet line encoder: accepts bytes and classifies them.
// Tracks whether a packet is open and attaches the preamble length to each job.
// Depends on dpe_pkg for cfg_t and job_t.
`timescale 1ns / 1ps

module dpe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [dpe_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_last_byte,
  output logic                       in_full,
  input  dpe_pkg::cfg_t              cfg,
  output logic                       q_push,
  output dpe_pkg::job_t              q_job,
  input  logic                       q_full
);

  logic inside_r, inside_nxt;
  logic accept;

  assign accept  = in_push & ~q_full;
  assign in_full = q_full;
  assign q_push  = accept;

  // A byte that opens a packet carries the preamble; later bytes carry none.
  assign q_job.pre_bits = inside_r ? '0 : cfg.pre_ones;
  assign q_job.data     = in_data_byte;
  assign q_job.last     = in_last_byte;

  // The packet stays open until a beat with the last-byte flag.
  assign inside_nxt = accept ? ~in_last_byte : inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

endmodule

>>> design/dpe_fifo.sv
// Short job queue between the front and back ends of the DCC packet line encoder.
// Depends on dpe_pkg for job_t and the queue geometry.
`timescale 1ns / 1ps

module dpe_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dpe_pkg::job_t wr_job,
  output logic          full,
  output logic          rd_valid,
  output dpe_pkg::job_t rd_job,
  input  logic          pop
);

  dpe_pkg::job_t                entry_r [dpe_pkg::Q_DEPTH];
  logic [dpe_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [dpe_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [dpe_pkg::Q_CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == dpe_pkg::Q_CNT_W'(dpe_pkg::Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dpe_pkg::Q_PTR_W'(dpe_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == dpe_pkg::Q_PTR_W'(dpe_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> design/dpe_back.sv
// Back end of the DCC packet line encoder: walks one job bit by bit and emits phases.
// Each bit gives a high then a low phase; a registered output stage holds the beat.
// Depends on dpe_pkg for cfg_t, job_t, seg_t and back_stat_t.
`timescale 1ns / 1ps

module dpe_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dpe_pkg::cfg_t             cfg,
  input  logic                      job_valid,
  input  dpe_pkg::job_t             job,
  output logic                      job_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic                      out_line_level,
  output logic [dpe_pkg::DUR_W-1:0] out_phase_cycles,
  output logic                      out_run_end,
  output dpe_pkg::back_stat_t       stat
);

  dpe_pkg::seg_t             state_r, state_nxt, seg_cur;
  logic [dpe_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_cur;
  logic                      half_r, half_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      level_r;
  logic [dpe_pkg::DUR_W-1:0] cycles_r;
  logic                      end_r;
  logic                      out_ready;
  logic                      step;
  logic                      bit_val;
  logic                      done;

  // The output stage takes a new phase when it is empty or being drained.
  assign out_ready = ~out_valid_r | out_pop;
  assign step      = job_valid & out_ready;

  // A fresh job starts in the preamble, or at the start bit when it has none.
  always_comb begin
    if (state_r == dpe_pkg::ST_LOAD) begin
      seg_cur = (job.pre_bits != '0) ? dpe_pkg::ST_PRE : dpe_pkg::ST_START;
      cnt_cur = job.pre_bits;
    end else begin
      seg_cur = state_r;
      cnt_cur = cnt_r;
    end
  end

  // Next segment: a fresh job's segment is taken on its high half, later moves after the low half of each bit
  always_comb begin
    state_nxt = state_r;
    if (step && !half_r) begin
      state_nxt = seg_cur;
    end else if (step) begin
      unique case (seg_cur)
        dpe_pkg::ST_PRE: begin
          if (cnt_cur == dpe_pkg::CNT_W'(1)) begin
            state_nxt = dpe_pkg::ST_START;
          end
        end
        dpe_pkg::ST_START: state_nxt = dpe_pkg::ST_DATA;
        dpe_pkg::ST_DATA: begin
          if (cnt_cur == '0) begin
            state_nxt = job.last ? dpe_pkg::ST_END : dpe_pkg::ST_LOAD;
          end
        end
        dpe_pkg::ST_END:  state_nxt = dpe_pkg::ST_LOAD;
        default:          state_nxt = dpe_pkg::ST_LOAD;
      endcase
    end
  end

  // Phase contents, counters and job release
  always_comb begin
    unique case (seg_cur)
      dpe_pkg::ST_START: bit_val = 1'b0;
      dpe_pkg::ST_DATA:  bit_val = job.data[cnt_cur[dpe_pkg::BIT_IDX_W-1:0]];
      default:           bit_val = 1'b1;
    endcase

    done = half_r & ((seg_cur == dpe_pkg::ST_END) |
                     ((seg_cur == dpe_pkg::ST_DATA) & (cnt_cur == '0) & ~job.last));
    job_pop = step & done;

    half_nxt = step ? ~half_r : half_r;

    cnt_nxt = cnt_r;
    if (step && !half_r) begin
      cnt_nxt = cnt_cur;
    end else if (step) begin
      unique case (seg_cur)
        dpe_pkg::ST_PRE:   cnt_nxt = cnt_cur - 1'b1;
        dpe_pkg::ST_START: cnt_nxt = dpe_pkg::CNT_W'(dpe_pkg::BYTE_W - 1);
        dpe_pkg::ST_DATA:  cnt_nxt = cnt_cur - 1'b1;
        default:           cnt_nxt = cnt_cur;
      endcase
    end

    out_valid_nxt = step | (out_valid_r & ~out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpe_pkg::ST_LOAD;
      cnt_r       <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output beat register: high half first, then low
  always_ff @(posedge clk) begin
    if (step) begin
      level_r  <= ~half_r;
      cycles_r <= bit_val ? cfg.one_cycles : cfg.zero_cycles;
      end_r    <= done;
    end
  end

  assign out_empty        = ~out_valid_r;
  assign out_line_level   = level_r;
  assign out_phase_cycles = cycles_r;
  assign out_run_end      = end_r;

  assign stat.idle = (state_r == dpe_pkg::ST_LOAD);
  assign stat.half = half_r;

endmodule
